FILE: sv/ubsc_pkg.sv
// Shared constants, register map and types for the UART baud source checker.
`timescale 1ns / 1ps
package ubsc_pkg;

  localparam int IDX_W    = 5;
  localparam int DATA_W   = 8;
  localparam int CLK_W    = 31;
  localparam int RATE_W   = 27;
  localparam int NUM_W    = CLK_W + 1;
  localparam int DEN_W    = 29;
  localparam int REM_W    = DEN_W + 1;
  localparam int CNT_W    = $clog2(NUM_W);
  localparam int NUM_REGS = 18;

  // Shadow register map
  localparam logic [IDX_W-1:0] REG_SCON  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PCON  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_CKSEL = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_TCON  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_TMOD  = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_CKCON = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_T34   = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_TH1   = IDX_W'(7);
  localparam logic [IDX_W-1:0] REG_TH4   = IDX_W'(8);
  localparam logic [IDX_W-1:0] REG_T2CON = IDX_W'(9);
  localparam logic [IDX_W-1:0] REG_RLDL  = IDX_W'(10);
  localparam logic [IDX_W-1:0] REG_RLDH  = IDX_W'(11);
  localparam logic [IDX_W-1:0] REG_BRTC  = IDX_W'(12);
  localparam logic [IDX_W-1:0] REG_BRTL  = IDX_W'(13);
  localparam logic [IDX_W-1:0] REG_BRTH  = IDX_W'(14);
  localparam logic [IDX_W-1:0] REG_PSRXD = IDX_W'(15);
  localparam logic [IDX_W-1:0] REG_P13   = IDX_W'(16);
  localparam logic [IDX_W-1:0] REG_P21   = IDX_W'(17);

  // Clock source selects
  localparam logic [2:0] SEL_T1  = 3'd0;
  localparam logic [2:0] SEL_T4  = 3'd1;
  localparam logic [2:0] SEL_T2  = 3'd2;
  localparam logic [2:0] SEL_BRT = 3'd3;

  // Alternate receive pin codes and the mux setting that routes the UART
  localparam logic [DATA_W-1:0] RXD_ALT_P13  = 8'h13;
  localparam logic [DATA_W-1:0] RXD_ALT_P21  = 8'h21;
  localparam logic [DATA_W-1:0] PIN_MUX_UART = 8'h03;

  // Timer mode field value for 8-bit auto-reload
  localparam logic [1:0] TMODE_AUTO_RELOAD = 2'd2;

  typedef struct packed {
    logic             mode_nr;
    logic             baud_nr;
    logic             rxd_nr;
    logic             rate_zero;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } eval_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

endpackage

FILE: sv/ubsc_if.sv
// Handshake channel interfaces for register write requests, results and configuration.
`timescale 1ns / 1ps
interface ubsc_in_if;
  import ubsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  reg_index;
  logic [DATA_W-1:0] write_value;

  modport source (output valid, output reg_index, output write_value, input ready);
  modport sink   (input valid, input reg_index, input write_value, output ready);
endinterface

interface ubsc_out_if;
  import ubsc_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode_not_ready;
  logic              baud_not_ready;
  logic              rxd_not_ready;
  logic [RATE_W-1:0] baud_rate_hz;

  modport source (output valid, output mode_not_ready, output baud_not_ready,
                  output rxd_not_ready, output baud_rate_hz, input ready);
  modport sink   (input valid, input mode_not_ready, input baud_not_ready,
                  input rxd_not_ready, input baud_rate_hz, output ready);
endinterface

interface ubsc_cfg_if;
  import ubsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CLK_W-1:0] system_clock_hz;

  modport source (output valid, output system_clock_hz, input ready);
  modport sink   (input valid, input system_clock_hz, output ready);
endinterface

FILE: sv/uart_baud_source_checker_unit.sv
// Top level of the UART baud source checker: request control, output register and divider.
`timescale 1ns / 1ps
// Usage
// Each request on in_ch writes one byte into one of eighteen shadowed UART and
// timer registers; an index above the register map writes nothing. For every
// request exactly one result leaves on out_ch: the mode, baud source and
// receive pin not-ready flags, and the baud rate in Hz (0 when undefined).
// The system clock frequency is written through cfg_ch, which is always ready;
// it should only be changed while no request is in flight.
// Timing: a request is taken in the idle state, the register file is updated
// at that edge, the next cycle forms the divider operands, and the restoring
// divider then works out the quotient one bit at a time. The result then
// enters the output register and in_ch.ready returns high in that same cycle;
// while a request is in flight, in_ch.ready stays low and no new one is taken.
// If the receiver stalls, the result waits in the output register while the
// next request is already taken; a second finished result waits in the divider
// until the register frees. Synchronous reset clears all shadow registers and
// the clock frequency to zero and empties the output register.
module uart_baud_source_checker_unit (
  input  logic   clk,
  input  logic   rst_n,
  ubsc_in_if.sink     in_ch,
  ubsc_out_if.source  out_ch,
  ubsc_cfg_if.sink    cfg_ch
);
  import ubsc_pkg::*;

  state_t            state_r, state_nxt;
  logic [CLK_W-1:0]  clk_hz_r;
  logic              mode_nr_r, baud_nr_r, rxd_nr_r, zero_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_mode_r, out_baud_r, out_rxd_r;
  logic [RATE_W-1:0] out_rate_r;

  logic              in_acc;
  logic              div_start;
  logic              ld_out;
  logic              slot_free;
  eval_t             eval;
  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [NUM_W-1:0]  div_quo;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Configuration: the system clock frequency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= '0;
    end else if (cfg_ch.valid) begin
      clk_hz_r <= cfg_ch.system_clock_hz;
    end
  end

  ubsc_shadow u_shadow (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc),
    .wr_index (in_ch.reg_index),
    .wr_data  (in_ch.write_value),
    .clk_hz   (clk_hz_r),
    .eval     (eval)
  );

  assign div_start   = (state_r == ST_LOAD);
  assign div_req.num = eval.num;
  assign div_req.den = eval.den;

  ubsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // The output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || out_ch.ready;
  assign ld_out    = (((state_r == ST_DIV) && div_stat.done) || (state_r == ST_HOLD))
                     && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = slot_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Flags are captured while the operands are handed to the divider.
  always_ff @(posedge clk) begin
    if (div_start) begin
      mode_nr_r <= eval.mode_nr;
      baud_nr_r <= eval.baud_nr;
      rxd_nr_r  <= eval.rxd_nr;
      zero_r    <= eval.rate_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_mode_r <= mode_nr_r;
      out_baud_r <= baud_nr_r;
      out_rxd_r  <= rxd_nr_r;
      out_rate_r <= zero_r ? '0 : div_quo[RATE_W-1:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mode_not_ready = out_mode_r;
  assign out_ch.baud_not_ready = out_baud_r;
  assign out_ch.rxd_not_ready  = out_rxd_r;
  assign out_ch.baud_rate_hz   = out_rate_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV)) else $error("divider finished outside a run");

  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r) else $error("holding with an empty output");

  a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out && zero_r |=> (out_ch.baud_rate_hz == '0)) else $error("undefined rate not zero");

  a_accept_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !div_stat.busy) else $error("request taken while dividing");

endmodule

FILE: sv/ubsc_shadow.sv
// Shadow register file with flag decode and divider operand formation.
`timescale 1ns / 1ps
module ubsc_shadow (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [ubsc_pkg::IDX_W-1:0]  wr_index,
  input  logic [ubsc_pkg::DATA_W-1:0] wr_data,
  input  logic [ubsc_pkg::CLK_W-1:0]  clk_hz,
  output ubsc_pkg::eval_t             eval
);
  import ubsc_pkg::*;

  logic [DATA_W-1:0] regs_r [NUM_REGS];

  logic [2:0]        sel;
  logic              running;
  logic              rxd_bad;
  logic [8:0]        n_t1;
  logic [8:0]        n_t4;
  logic [16:0]       n_t2;
  logic [16:0]       n_brt;
  logic [10:0]       m_t1;
  logic [10:0]       m_t4;
  logic [18:0]       m_t2;
  logic [DEN_W-1:0]  den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr_en && (wr_index < IDX_W'(NUM_REGS))) begin
      regs_r[wr_index] <= wr_data;
    end
  end

  always_comb begin
    sel   = regs_r[REG_CKSEL][2:0];
    n_t1  = 9'd256 - {1'b0, regs_r[REG_TH1]};
    n_t4  = 9'd256 - {1'b0, regs_r[REG_TH4]};
    n_t2  = 17'h10000 - {1'b0, regs_r[REG_RLDH], regs_r[REG_RLDL]};
    n_brt = 17'h10000 - {1'b0, regs_r[REG_BRTH], regs_r[REG_BRTL]};
    // Divide-by-three prescale is folded in as n*3 ahead of the power-of-two shift.
    m_t1  = regs_r[REG_CKCON][4] ? {2'b0, n_t1} : ({1'b0, n_t1, 1'b0} + {2'b0, n_t1});
    m_t4  = regs_r[REG_T34][6]   ? {2'b0, n_t4} : ({1'b0, n_t4, 1'b0} + {2'b0, n_t4});
    m_t2  = {1'b0, n_t2, 1'b0} + {2'b0, n_t2};

    running = 1'b0;
    den     = '0;
    unique case (sel)
      SEL_T1: begin
        running = regs_r[REG_TCON][6] && (regs_r[REG_TMOD][5:4] == TMODE_AUTO_RELOAD);
        den     = DEN_W'(m_t1) << 7;
      end
      SEL_T4: begin
        running = regs_r[REG_T34][7];
        den     = DEN_W'(m_t4) << 7;
      end
      SEL_T2: begin
        running = regs_r[REG_T2CON][1:0] != 2'b00;
        den     = DEN_W'(m_t2) << (regs_r[REG_T2CON][7] ? 8 : 7);
      end
      SEL_BRT: begin
        running = regs_r[REG_BRTC][7];
        den     = DEN_W'(n_brt) << (5 + regs_r[REG_BRTC][2:0]);
      end
      default: begin
        running = 1'b0;
        den     = '0;
      end
    endcase

    rxd_bad = ((regs_r[REG_PSRXD] == RXD_ALT_P13) && (regs_r[REG_P13] != PIN_MUX_UART)) ||
              ((regs_r[REG_PSRXD] == RXD_ALT_P21) && (regs_r[REG_P21] != PIN_MUX_UART));

    eval.mode_nr   = !regs_r[REG_SCON][6];
    eval.baud_nr   = !running;
    eval.rxd_nr    = regs_r[REG_SCON][4] && rxd_bad;
    eval.rate_zero = (clk_hz == '0) || sel[2] || (den == '0) ||
                     ((sel == SEL_T4) && (regs_r[REG_T34][5:4] != TMODE_AUTO_RELOAD));
    eval.num       = regs_r[REG_PCON][7] ? {clk_hz, 1'b0} : {1'b0, clk_hz};
    eval.den       = den;
  end

endmodule

FILE: sv/ubsc_div.sv
// Radix-2 restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module ubsc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  ubsc_pkg::div_req_t         req,
  output ubsc_pkg::div_stat_t        stat,
  output logic [ubsc_pkg::NUM_W-1:0] quotient
);
  import ubsc_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [REM_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W:0]   diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r[REM_W-2:0], quo_r[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = !diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[REM_W-1:0] : rem_sh;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without a run");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the UART baud source checker unit.
`timescale 1ns / 1ps
module tb;
  import ubsc_pkg::*;

  // The block never idles for long on its own, so any silence longer than this is a hang.
  localparam int WATCHDOG_LIMIT = 3000;
  // Settling pauses allow for the time a request needs from acceptance to result.
  localparam int SETTLE_CYCLES  = 48;
  localparam int HOLD_CYCLES    = 400;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic              mode_nr;
    logic              baud_nr;
    logic              rxd_nr;
    logic [RATE_W-1:0] rate;
  } baud_report_t;

  logic clk = 1'b0;
  logic rst_n;

  ubsc_in_if  in_ch();
  ubsc_out_if out_ch();
  ubsc_cfg_if cfg_ch();

  uart_baud_source_checker_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Our own copy of the shadowed UART and timer registers, and of the clock frequency.
  logic [DATA_W-1:0] shadow_copy [NUM_REGS];
  logic [CLK_W-1:0]  sysclk_hz;

  baud_report_t pending_reports[$];
  int           fail_count;
  int           mismatch_count;
  int           burst_left;
  bit           offering;
  bit           hold_req;
  int           idle_cycles;

  // Applies one register write request to the copy, then works out the flags and the rate
  // that the block should report for the registers as they now stand.
  function automatic baud_report_t predict_write(input logic [IDX_W-1:0] idx,
                                                 input logic [DATA_W-1:0] val);
    baud_report_t      rep;
    logic [2:0]        sel;
    logic              running;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   mult;
    longint unsigned   reload;
    if (idx < NUM_REGS) begin
      shadow_copy[idx] = val;
    end
    sel = shadow_copy[REG_CKSEL][2:0];
    rep.mode_nr = !shadow_copy[REG_SCON][6];
    case (sel)
      SEL_T1:  running = shadow_copy[REG_TCON][6] &&
                         (shadow_copy[REG_TMOD][5:4] == TMODE_AUTO_RELOAD);
      SEL_T4:  running = shadow_copy[REG_T34][7];
      SEL_T2:  running = (shadow_copy[REG_T2CON][1:0] != 2'd0);
      SEL_BRT: running = shadow_copy[REG_BRTC][7];
      default: running = 1'b0;
    endcase
    rep.baud_nr = !running;
    // The receive pin flag only matters when reception is enabled and an alternate pin is chosen.
    rep.rxd_nr = shadow_copy[REG_SCON][4] &&
                 (((shadow_copy[REG_PSRXD] == RXD_ALT_P13) &&
                   (shadow_copy[REG_P13] != PIN_MUX_UART)) ||
                  ((shadow_copy[REG_PSRXD] == RXD_ALT_P21) &&
                   (shadow_copy[REG_P21] != PIN_MUX_UART)));
    num = longint'(sysclk_hz) * (shadow_copy[REG_PCON][7] ? 2 : 1);
    reload = {shadow_copy[REG_RLDH], shadow_copy[REG_RLDL]};
    den = 0;
    case (sel)
      SEL_T1: begin
        mult = shadow_copy[REG_CKCON][4] ? 1 : 3;
        den = 128 * mult * (256 - longint'(shadow_copy[REG_TH1]));
      end
      SEL_T4: begin
        // Timer 4 only gives a rate in its auto-reload mode.
        if (shadow_copy[REG_T34][5:4] == TMODE_AUTO_RELOAD) begin
          mult = shadow_copy[REG_T34][6] ? 1 : 3;
          den = 128 * mult * (256 - longint'(shadow_copy[REG_TH4]));
        end
      end
      SEL_T2: begin
        mult = shadow_copy[REG_T2CON][7] ? 2 : 1;
        den = 384 * mult * (65536 - reload);
      end
      SEL_BRT: begin
        reload = {shadow_copy[REG_BRTH], shadow_copy[REG_BRTL]};
        mult = 64'd1 << shadow_copy[REG_BRTC][2:0];
        den = 32 * mult * (65536 - reload);
      end
      default: den = 0;
    endcase
    if (sysclk_hz == '0 || den == 0) begin
      rep.rate = '0;
    end else begin
      rep.rate = RATE_W'(num / den);
    end
    return rep;
  endfunction

  // Drops the request valid if it was left high for a burst, and waits for a clock edge so that
  // no later drive lands in the same time step.
  task automatic quiesce_writes();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
  endtask

  // Offers one write request and waits for it to be taken. The sender keeps valid high within
  // a burst and pauses for a random gap, possibly none, between bursts.
  task automatic send_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.reg_index   <= idx;
    in_ch.write_value <= val;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_reports.push_back(predict_write(idx, val));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // The clock frequency may only change once every request in flight has produced its result.
  task automatic set_clock(input logic [CLK_W-1:0] hz);
    quiesce_writes();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.system_clock_hz <= hz;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sysclk_hz = hz;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random requests lean towards settings that get a clock source running and an alternate
  // pin routed, with a share of writes to indices outside the register map.
  task automatic random_write();
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] val;
    int                pick;
    if ($urandom_range(0, 99) < 8) begin
      idx = IDX_W'($urandom_range(NUM_REGS, 31));
    end else begin
      idx = IDX_W'($urandom_range(0, NUM_REGS - 1));
    end
    val = DATA_W'($urandom);
    pick = $urandom_range(0, 3);
    case (idx) inside
      REG_CKSEL: begin
        if (pick != 0) val[2:0] = 3'($urandom_range(0, 3));
      end
      REG_TMOD, REG_T34: begin
        if (pick < 2) val[5:4] = TMODE_AUTO_RELOAD;
      end
      REG_PSRXD: begin
        if (pick == 0) val = RXD_ALT_P13;
        else if (pick == 1) val = RXD_ALT_P21;
      end
      REG_P13, REG_P21: begin
        if (pick < 2) val = PIN_MUX_UART;
      end
      REG_SCON: begin
        if (pick != 0) val[6] = 1'b1;
      end
      default: ;
    endcase
    send_write(idx, val);
  endtask

  // With the reset registers and a zero clock, writes outside the map must change nothing.
  task automatic test_unmapped_index();
    send_write(IDX_W'(NUM_REGS), 8'hFF);
    send_write(IDX_W'(31), 8'hAA);
  endtask

  task automatic test_timer1_source();
    send_write(REG_SCON, 8'h50);
    send_write(REG_PCON, 8'h80);
    send_write(REG_TCON, 8'h40);
    send_write(REG_TMOD, 8'h20);
    send_write(REG_CKCON, 8'h10);
    send_write(REG_TH1, 8'hFF);
  endtask

  // The last write leaves Timer 4 running but outside auto-reload, so the rate drops to zero.
  task automatic test_timer4_source();
    send_write(REG_CKSEL, {5'd0, SEL_T4});
    send_write(REG_T34, 8'hE0);
    send_write(REG_TH4, 8'hFD);
    send_write(REG_T34, 8'h90);
  endtask

  // A full reload of 0xFFFF gives the smallest divisor; then the largest prescale.
  task automatic test_timer2_and_brt();
    send_write(REG_CKSEL, {5'd0, SEL_T2});
    send_write(REG_T2CON, 8'h81);
    send_write(REG_RLDL, 8'hFF);
    send_write(REG_RLDH, 8'hFF);
    send_write(REG_CKSEL, {5'd0, SEL_BRT});
    send_write(REG_BRTC, 8'h87);
  endtask

  task automatic test_reserved_select();
    send_write(REG_CKSEL, 8'h07);
    send_write(REG_CKSEL, 8'hFC);
  endtask

  // Each alternate receive pin first without and then with its UART mux setting.
  task automatic test_rxd_pins();
    send_write(REG_PSRXD, RXD_ALT_P13);
    send_write(REG_P13, PIN_MUX_UART);
    send_write(REG_PSRXD, RXD_ALT_P21);
    send_write(REG_P21, PIN_MUX_UART);
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so that both the
  // output register and the divider fill and the block has to refuse further requests.
  task automatic test_output_backpressure();
    int i;
    hold_req = 1'b1;
    burst_left = 16;
    for (i = 0; i < 12; i++) begin
      random_write();
    end
  endtask

  // Random requests under a run of clock settings, including both ends of the clock range.
  task automatic test_random_clock_sweep();
    logic [CLK_W-1:0] sweep [9];
    int p;
    int i;
    sweep[0] = '1;
    sweep[1] = '0;
    sweep[2] = CLK_W'(1);
    sweep[3] = CLK_W'(24_000_000);
    sweep[4] = CLK_W'($urandom);
    sweep[5] = CLK_W'(11_059_200);
    sweep[6] = CLK_W'($urandom);
    sweep[7] = CLK_W'(32'h4000_0000);
    sweep[8] = CLK_W'($urandom_range(1, 100_000));
    for (p = 0; p < 9; p++) begin
      set_clock(sweep[p]);
      for (i = 0; i < 66; i++) begin
        random_write();
      end
    end
  endtask

  // Receiver: a ready pattern that changes after a random stretch, and on request a long hold.
  initial begin
    int pattern;
    int pattern_left;
    int tick;
    out_ch.ready <= 1'b0;
    pattern = 0;
    pattern_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (pattern_left == 0) begin
          pattern = $urandom_range(0, 3);
          pattern_left = $urandom_range(40, 200);
        end
        pattern_left--;
        case (pattern)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // Each result is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    baud_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result: mode_nr=%0b baud_nr=%0b rxd_nr=%0b rate=%0d",
                   out_ch.mode_not_ready, out_ch.baud_not_ready, out_ch.rxd_not_ready,
                   out_ch.baud_rate_hz);
        end
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.mode_not_ready !== want.mode_nr ||
            out_ch.baud_not_ready !== want.baud_nr ||
            out_ch.rxd_not_ready  !== want.rxd_nr  ||
            out_ch.baud_rate_hz   !== want.rate) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch: expected mode_nr=%0b baud_nr=%0b rxd_nr=%0b rate=%0d",
                     want.mode_nr, want.baud_nr, want.rxd_nr, want.rate);
            $display("          actual   mode_nr=%0b baud_nr=%0b rxd_nr=%0b rate=%0d",
                     out_ch.mode_not_ready, out_ch.baud_not_ready, out_ch.rxd_not_ready,
                     out_ch.baud_rate_hz);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which no request, result or clock write is accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.reg_index        <= '0;
    in_ch.write_value      <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.system_clock_hz <= '0;
    fail_count = 0;
    mismatch_count = 0;
    burst_left = 0;
    offering = 1'b0;
    hold_req = 1'b0;
    sysclk_hz = '0;
    for (i = 0; i < NUM_REGS; i++) begin
      shadow_copy[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unmapped_index();
    set_clock('1);
    test_timer1_source();
    test_timer4_source();
    test_timer2_and_brt();
    test_reserved_select();
    test_rxd_pins();
    test_output_backpressure();
    test_random_clock_sweep();

    quiesce_writes();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
